[hw/rtl/idalloc_pkg.sv]
// Shared types and constants for the identifier allocator.
// Request/response beat structs, op codes and the stack command struct.
// No dependencies.
package idalloc_pkg;

	localparam int unsigned IDENT_W     = 10;
	localparam int unsigned MAX_IDS_DEF = 1024;

	localparam logic [1:0] OP_CREATE  = 2'd0;
	localparam logic [1:0] OP_DESTROY = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic [IDENT_W-1:0] ident;
	} req_t;

	typedef struct packed {
		logic [IDENT_W-1:0] ident_out;
		logic               live;
		logic               status;
	} rsp_t;

	// Commit-stage request to the free stack; push and pop never both set
	typedef struct packed {
		logic               push;
		logic               pop;
		logic [IDENT_W-1:0] push_id;
	} stk_cmd_t;

endpackage

[hw/rtl/id_allocator_free_stack.sv]
// Identifier allocator: free stack of released ids, fresh-id counter, live bitmap.
// Usage notes below. Depends on idalloc_pkg and idalloc_stack.
//
// Request channel: a beat (req.op, req.ident) is taken at a rising edge with
// start high and busy low. op create allocates an id (stack first, then the
// fresh counter), destroy releases a live id, query (and the spare code)
// reports liveness.
// Response channel: done pulses for exactly one cycle with rsp valid; the
// receiver cannot stall it, so it must take every beat.
// Pipeline: the accepting edge reads the stack top and the live bit from their
// memories into the commit stage; the commit stage does the read-modify-write
// and registers done and rsp. A new request is not taken while one is in the
// commit stage: busy is high during that commit cycle.
// Reset: arst_n clears the fresh counter, stack depth and pipeline. The live
// bitmap needs no clearing pass: an id at or above the fresh counter has never
// been handed out and reads as not live, every id below it has been written.
// Create with an empty stack and the counter at MAX_IDS answers status 1.
module id_allocator_free_stack #(
	parameter int unsigned MAX_IDS = idalloc_pkg::MAX_IDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  idalloc_pkg::req_t req,
	output logic              done,
	output idalloc_pkg::rsp_t rsp
);
	import idalloc_pkg::*;

	localparam int unsigned AW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam int unsigned CW = $clog2(MAX_IDS + 1);

	logic               accept;
	logic               valid_s1;
	req_t               req_s1;
	logic               lm_rd_s1;
	logic [CW-1:0]      next_fresh_q;
	logic               done_q;
	rsp_t               rsp_q;

	logic               live_map [MAX_IDS];
	logic [31:0]        req32;
	logic [31:0]        id32;
	logic [31:0]        fresh32;
	logic [31:0]        top32;
	logic [IDENT_W-1:0] stk_top;
	logic               stk_empty;
	stk_cmd_t           stk_cmd;

	logic               is_create;
	logic               is_destroy;
	logic               was_live;
	logic               do_pop;
	logic               do_fresh;
	logic               destroy_hit;
	logic [IDENT_W-1:0] new_id;
	logic [AW-1:0]      new_addr;
	logic               lm_we;
	logic [AW-1:0]      lm_wr_addr;
	rsp_t               rsp_n;

	assign busy   = valid_s1;
	assign accept = start & ~busy;
	assign done   = done_q;
	assign rsp    = rsp_q;

	// Request capture and live-bit read
	assign req32 = 32'(req.ident);

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1   <= req;
			lm_rd_s1 <= live_map[req32[AW-1:0]];
		end
		if (lm_we) begin
			live_map[lm_wr_addr] <= ~destroy_hit;
		end
	end

	// Commit stage decode
	assign id32       = 32'(req_s1.ident);
	assign fresh32    = 32'(next_fresh_q);
	assign top32      = 32'(stk_top);
	assign is_create  = (req_s1.op == OP_CREATE);
	assign is_destroy = (req_s1.op == OP_DESTROY);
	assign was_live   = lm_rd_s1 & (id32 < fresh32);

	assign do_pop      = valid_s1 & is_create & ~stk_empty;
	assign do_fresh    = valid_s1 & is_create & stk_empty & (fresh32 < 32'(MAX_IDS));
	assign destroy_hit = valid_s1 & is_destroy & was_live;

	assign new_id   = do_pop ? stk_top : fresh32[IDENT_W-1:0];
	assign new_addr = do_pop ? top32[AW-1:0] : fresh32[AW-1:0];

	assign lm_we      = do_pop | do_fresh | destroy_hit;
	assign lm_wr_addr = destroy_hit ? id32[AW-1:0] : new_addr;

	assign stk_cmd = '{push: destroy_hit, pop: do_pop, push_id: req_s1.ident};

	// Response word
	always_comb begin
		rsp_n.ident_out = req_s1.ident;
		rsp_n.live      = was_live;
		rsp_n.status    = 1'b0;
		if (is_create) begin
			if (do_pop || do_fresh) begin
				rsp_n.ident_out = new_id;
				rsp_n.live      = 1'b1;
			end else begin
				rsp_n.ident_out = '0;
				rsp_n.live      = 1'b0;
				rsp_n.status    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q <= rsp_n;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			done_q       <= 1'b0;
			next_fresh_q <= '0;
		end else begin
			valid_s1 <= accept;
			done_q   <= valid_s1;
			if (do_fresh) begin
				next_fresh_q <= next_fresh_q + CW'(1);
			end
		end
	end

	idalloc_stack #(
		.MAX_IDS(MAX_IDS)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.cmd    (stk_cmd),
		.top    (stk_top),
		.empty  (stk_empty)
	);

`ifndef SYNTH
	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(next_fresh_q) <= 32'(MAX_IDS))
		else $error("fresh counter beyond capacity");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> !valid_s1)
		else $error("second request entered commit stage back to back");

	a_done_follows_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("response beat without a committed request");

	a_exhaust_only_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status) |-> $past(stk_empty))
		else $error("create failed while free stack held ids");
`endif

endmodule

[hw/rtl/idalloc_stack.sv]
// LIFO free stack of released identifiers: one synchronous memory plus depth pointer.
// Depends on idalloc_pkg.
module idalloc_stack #(
	parameter int unsigned MAX_IDS = idalloc_pkg::MAX_IDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_en,
	input  idalloc_pkg::stk_cmd_t             cmd,
	output logic [idalloc_pkg::IDENT_W-1:0]   top,
	output logic                              empty
);
	import idalloc_pkg::*;

	localparam int unsigned AW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam int unsigned CW = $clog2(MAX_IDS + 1);

	logic [IDENT_W-1:0] mem [MAX_IDS];
	logic [CW-1:0]      depth_q;
	logic [CW-1:0]      depth_m1;

	assign depth_m1 = depth_q - CW'(1);
	assign empty    = (depth_q == '0);

	// Top-of-stack read, registered when rd_en is high; address is junk when empty
	always_ff @(posedge clk) begin
		if (rd_en) begin
			top <= mem[depth_m1[AW-1:0]];
		end
		if (cmd.push) begin
			mem[depth_q[AW-1:0]] <= cmd.push_id;
		end
	end

	// Depth pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (cmd.push) begin
			depth_q <= depth_q + CW'(1);
		end else if (cmd.pop) begin
			depth_q <= depth_m1;
		end
	end

endmodule
